>>> src/jmdp_pkg.sv
// Package for the JPEG MCU block sequencer with DC prediction.
// Holds field widths, register indexes, request codes and geometry decoding.
// No dependencies.
package jmdp_pkg;

    localparam int DEF_MAX_SLOTS  = 4;
    localparam int DEF_COORD_BITS = 13;
    localparam int DEF_DC_BITS    = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SCAN_W     = 3;
    localparam int MCU_COLS_W = 14;
    localparam int GEOM_W     = 32;
    localparam int SUB_W      = 3;
    localparam int BX_W       = 13;
    localparam int LIN_BITS   = 26;

    localparam int REQ_TYPE_W = 2;
    localparam int DC_W       = 16;
    localparam int SLOT_OUT_W = 2;
    localparam int COL_OUT_W  = 13;
    localparam int ROW_OUT_W  = 13;

    localparam logic [CFG_IDX_W-1:0] REG_SCAN_COMPONENTS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MCU_COLUMNS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT0_GEOMETRY  = 3'd2;

    localparam logic [SCAN_W-1:0]     SCAN_COMPONENTS_RESET = 3'd1;
    localparam logic [MCU_COLS_W-1:0] MCU_COLUMNS_RESET     = 14'd1;
    localparam logic [GEOM_W-1:0]     GEOM_RESET            = 32'h0008_0049;
    localparam logic [LIN_BITS-1:0]   GEOM_RESET_AREA       =
        LIN_BITS'(GEOM_RESET[18:6]) * LIN_BITS'(GEOM_RESET[31:19]);

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_START   = 2'd0,
        REQ_RESTART = 2'd1,
        REQ_BLOCK   = 2'd2
    } req_type_t;

    function automatic logic [SUB_W-1:0] geom_h(input logic [GEOM_W-1:0] g);
        return (g[2:0] == '0) ? SUB_W'(1) : g[2:0];
    endfunction

    function automatic logic [SUB_W-1:0] geom_v(input logic [GEOM_W-1:0] g);
        return (g[5:3] == '0) ? SUB_W'(1) : g[5:3];
    endfunction

    function automatic logic [BX_W-1:0] geom_bx(input logic [GEOM_W-1:0] g);
        return g[18:6];
    endfunction

    function automatic logic [BX_W-1:0] geom_by(input logic [GEOM_W-1:0] g);
        return g[31:19];
    endfunction

endpackage

>>> src/jmdp_if.sv
// Channel interfaces of the JPEG MCU block sequencer: request and result.
// Depends on jmdp_pkg for field widths.
interface jmdp_item_if;
    import jmdp_pkg::*;
    logic                         valid;
    logic                         ready;
    logic [REQ_TYPE_W-1:0]        req_type;
    logic signed [DC_W-1:0]       dc_diff;

    modport source (output valid, output req_type, output dc_diff, input ready);
    modport sink   (input valid, input req_type, input dc_diff, output ready);
endinterface

interface jmdp_result_if;
    import jmdp_pkg::*;
    logic                         valid;
    logic                         ready;
    logic [SLOT_OUT_W-1:0]        slot;
    logic [COL_OUT_W-1:0]         block_col;
    logic [ROW_OUT_W-1:0]         block_row;
    logic [LIN_BITS-1:0]          block_index;
    logic signed [DC_W-1:0]       dc_value;
    logic                         past_end;
    logic                         mcu_last;

    modport source (output valid, output slot, output block_col, output block_row,
                    output block_index, output dc_value, output past_end,
                    output mcu_last, input ready);
    modport sink   (input valid, input slot, input block_col, input block_row,
                    input block_index, input dc_value, input past_end,
                    input mcu_last, output ready);
endinterface

>>> src/jpeg_mcu_block_sequencer_dc_predict_top.sv
// JPEG baseline MCU block sequencer with per-slot DC prediction.
// Pipeline: an accepted block is registered in the first stage, then in the output register.
// Throughput: one transaction per cycle while the result channel is ready. After each configuration
// write the request channel holds ready low while a bit-serial divider rebuilds the
// single-component column and row counters from the linear block count.
// Reset: asynchronous, active low; restores configuration defaults, clears predictors and counters.
module jpeg_mcu_block_sequencer_dc_predict_top #(
    parameter int MAX_SLOTS  = jmdp_pkg::DEF_MAX_SLOTS,
    parameter int COORD_BITS = jmdp_pkg::DEF_COORD_BITS,
    parameter int DC_BITS    = jmdp_pkg::DEF_DC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [jmdp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jmdp_pkg::CFG_DATA_W-1:0] cfg_data,
    jmdp_item_if.sink                       item,
    jmdp_result_if.source                   result
);
    import jmdp_pkg::*;

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int POS_W  = (COORD_BITS + SUB_W > COL_OUT_W) ? COORD_BITS + SUB_W : COL_OUT_W;
    localparam int MUL_W  = POS_W + BX_W;
    localparam int CNT_W  = $clog2(LIN_BITS + 1);

    // configuration
    logic [SCAN_W-1:0]     scan_comp_reg;
    logic [MCU_COLS_W-1:0] mcu_columns_reg;
    logic [GEOM_W-1:0]     geom_reg [MAX_SLOTS];
    logic [LIN_BITS-1:0]   area_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_comp_reg   <= SCAN_COMPONENTS_RESET;
            mcu_columns_reg <= MCU_COLUMNS_RESET;
            for (int k = 0; k < MAX_SLOTS; k++)
            begin
                geom_reg[k] <= GEOM_RESET;
            end
            area_reg        <= GEOM_RESET_AREA;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SCAN_COMPONENTS: scan_comp_reg   <= cfg_data[SCAN_W-1:0];
                    REG_MCU_COLUMNS:     mcu_columns_reg <= cfg_data[MCU_COLS_W-1:0];
                    default:
                    begin
                        for (int k = 0; k < MAX_SLOTS; k++)
                        begin
                            if (cfg_index == CFG_IDX_W'(REG_SLOT0_GEOMETRY + k))
                            begin
                                geom_reg[k] <= cfg_data;
                            end
                        end
                    end
                endcase
            end
            area_reg <= LIN_BITS'(geom_bx(geom_reg[0])) * LIN_BITS'(geom_by(geom_reg[0]));
        end
    end

    // state
    logic [DC_BITS-1:0]    pred_reg [MAX_SLOTS];
    logic [DC_BITS-1:0]    pred_next [MAX_SLOTS];
    logic [COORD_BITS-1:0] mcu_col_reg, mcu_col_next;
    logic [COORD_BITS-1:0] mcu_row_reg, mcu_row_next;
    logic [SLOT_W-1:0]     slot_pos_reg, slot_pos_next;
    logic [SUB_W-1:0]      sub_h_reg, sub_h_next;
    logic [SUB_W-1:0]      sub_v_reg, sub_v_next;
    logic [LIN_BITS-1:0]   lin_reg, lin_next;
    logic [BX_W-1:0]       lcol_reg, lcol_next;
    logic [ROW_OUT_W-1:0]  lrow_reg, lrow_next;

    // divider pass
    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [LIN_BITS-1:0]   num_reg, num_next;
    logic [BX_W-1:0]       rem_reg, rem_next;
    logic [ROW_OUT_W-1:0]  quo_reg, quo_next;
    logic [BX_W:0]         trial;
    logic                  qbit;

    // pipeline
    logic                  s1_valid_reg, s1_valid_next;
    logic [SLOT_OUT_W-1:0] s1_slot_reg;
    logic [POS_W-1:0]      s1_col_reg, s1_row_reg;
    logic [BX_W-1:0]       s1_bx_reg;
    logic                  s1_lin_mode_reg;
    logic [LIN_BITS-1:0]   s1_lin_reg;
    logic signed [DC_W-1:0] s1_dc_reg;
    logic                  s1_past_reg, s1_last_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_free, s1_free, accept, produce;

    // item decode
    logic [SCAN_W-1:0]     ns_eff;
    logic                  lin_mode;
    logic [GEOM_W-1:0]     g_sel;
    logic [SUB_W-1:0]      h_sel, v_sel;
    logic [BX_W-1:0]       bx_sel, by_sel, bx0;
    logic [POS_W-1:0]      m_col, m_row, l_col, l_row;
    logic [SLOT_W-1:0]     pslot;
    logic [DC_BITS-1:0]    dc_sum;
    logic [SUB_W-1:0]      sub_h_inc, sub_v_inc;
    logic [MCU_COLS_W-1:0] nc;
    logic                  mcu_end;

    assign out_free   = !out_valid_reg || result.ready;
    assign s1_free    = !s1_valid_reg || out_free;
    assign item.ready = s1_free && !busy_reg;
    assign accept     = item.valid && item.ready;

    assign ns_eff   = (scan_comp_reg > SCAN_W'(MAX_SLOTS)) ? SCAN_W'(MAX_SLOTS) : scan_comp_reg;
    assign lin_mode = (ns_eff == SCAN_W'(1));
    assign produce  = accept && (item.req_type == REQ_BLOCK) && (ns_eff != '0);

    assign g_sel  = geom_reg[slot_pos_reg];
    assign h_sel  = geom_h(g_sel);
    assign v_sel  = geom_v(g_sel);
    assign bx_sel = geom_bx(g_sel);
    assign by_sel = geom_by(g_sel);
    assign bx0    = geom_bx(geom_reg[0]);

    assign m_col = POS_W'(mcu_col_reg) * POS_W'(h_sel) + POS_W'(sub_h_reg);
    assign m_row = POS_W'(mcu_row_reg) * POS_W'(v_sel) + POS_W'(sub_v_reg);
    assign l_col = (bx0 == '0) ? '0 : POS_W'(lcol_reg);
    assign l_row = (bx0 == '0) ? POS_W'(lin_reg[ROW_OUT_W-1:0]) : POS_W'(lrow_reg);

    assign pslot  = lin_mode ? '0 : slot_pos_reg;
    assign dc_sum = DC_BITS'(item.dc_diff) + pred_reg[pslot];

    assign sub_h_inc = sub_h_reg + 1'b1;
    assign sub_v_inc = sub_v_reg + 1'b1;
    assign nc        = MCU_COLS_W'(mcu_col_reg) + 1'b1;
    assign mcu_end   = (sub_h_inc >= h_sel) && (sub_v_inc >= v_sel)
                       && (SCAN_W'(slot_pos_reg) + 1'b1 >= ns_eff);

    assign trial = {rem_reg, num_reg[LIN_BITS-1]};
    assign qbit  = (trial >= (BX_W+1)'(bx0));

    always_comb
    begin
        pred_next     = pred_reg;
        mcu_col_next  = mcu_col_reg;
        mcu_row_next  = mcu_row_reg;
        slot_pos_next = slot_pos_reg;
        sub_h_next    = sub_h_reg;
        sub_v_next    = sub_v_reg;
        lin_next      = lin_reg;
        lcol_next     = lcol_reg;
        lrow_next     = lrow_reg;
        busy_next     = busy_reg;
        cnt_next      = cnt_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;

        if (busy_reg)
        begin
            rem_next = qbit ? BX_W'(trial - (BX_W+1)'(bx0)) : BX_W'(trial);
            quo_next = {quo_reg[ROW_OUT_W-2:0], qbit};
            num_next = {num_reg[LIN_BITS-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(LIN_BITS - 1))
            begin
                busy_next = 1'b0;
                lcol_next = rem_next;
                lrow_next = quo_next;
            end
        end

        if (cfg_we)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = lin_reg;
            rem_next  = '0;
        end

        if (accept)
        begin
            case (item.req_type)
                REQ_START:
                begin
                    for (int k = 0; k < MAX_SLOTS; k++)
                    begin
                        pred_next[k] = '0;
                    end
                    mcu_col_next  = '0;
                    mcu_row_next  = '0;
                    slot_pos_next = '0;
                    sub_h_next    = '0;
                    sub_v_next    = '0;
                    lin_next      = '0;
                    lcol_next     = '0;
                    lrow_next     = '0;
                end
                REQ_RESTART:
                begin
                    for (int k = 0; k < MAX_SLOTS; k++)
                    begin
                        pred_next[k] = '0;
                    end
                end
                REQ_BLOCK:
                begin
                    if (ns_eff != '0)
                    begin
                        pred_next[pslot] = dc_sum;
                        if (lin_mode)
                        begin
                            if (&lin_reg)
                            begin
                                lin_next  = '0;
                                lcol_next = '0;
                                lrow_next = '0;
                            end
                            else
                            begin
                                lin_next = lin_reg + 1'b1;
                                if ((BX_W+1)'(lcol_reg) + 1'b1 >= (BX_W+1)'(bx0))
                                begin
                                    lcol_next = '0;
                                    lrow_next = lrow_reg + 1'b1;
                                end
                                else
                                begin
                                    lcol_next = lcol_reg + 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            sub_h_next = sub_h_inc;
                            if (sub_h_inc >= h_sel)
                            begin
                                sub_h_next = '0;
                                sub_v_next = sub_v_inc;
                                if (sub_v_inc >= v_sel)
                                begin
                                    sub_v_next = '0;
                                    if (mcu_end)
                                    begin
                                        slot_pos_next = '0;
                                        if (nc >= mcu_columns_reg || (&mcu_col_reg))
                                        begin
                                            mcu_col_next = '0;
                                            mcu_row_next = mcu_row_reg + 1'b1;
                                        end
                                        else
                                        begin
                                            mcu_col_next = COORD_BITS'(nc);
                                        end
                                    end
                                    else
                                    begin
                                        slot_pos_next = slot_pos_reg + 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = produce ? 1'b1 : (out_free ? 1'b0 : s1_valid_reg);
        out_valid_next = (s1_valid_reg && out_free) ? 1'b1
                       : (result.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_SLOTS; k++)
            begin
                pred_reg[k] <= '0;
            end
            mcu_col_reg   <= '0;
            mcu_row_reg   <= '0;
            slot_pos_reg  <= '0;
            sub_h_reg     <= '0;
            sub_v_reg     <= '0;
            lin_reg       <= '0;
            lcol_reg      <= '0;
            lrow_reg      <= '0;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            num_reg       <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pred_reg      <= pred_next;
            mcu_col_reg   <= mcu_col_next;
            mcu_row_reg   <= mcu_row_next;
            slot_pos_reg  <= slot_pos_next;
            sub_h_reg     <= sub_h_next;
            sub_v_reg     <= sub_v_next;
            lin_reg       <= lin_next;
            lcol_reg      <= lcol_next;
            lrow_reg      <= lrow_next;
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            num_reg       <= num_next;
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // first stage payload: position, predicted DC and flags
    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            s1_lin_mode_reg <= lin_mode;
            s1_lin_reg      <= lin_reg;
            s1_dc_reg       <= DC_W'(signed'(dc_sum));
            if (lin_mode)
            begin
                s1_slot_reg <= '0;
                s1_col_reg  <= l_col;
                s1_row_reg  <= l_row;
                s1_bx_reg   <= bx0;
                s1_past_reg <= (lin_reg >= area_reg);
                s1_last_reg <= 1'b1;
            end
            else
            begin
                s1_slot_reg <= SLOT_OUT_W'(slot_pos_reg);
                s1_col_reg  <= m_col;
                s1_row_reg  <= m_row;
                s1_bx_reg   <= bx_sel;
                s1_past_reg <= (m_col >= POS_W'(bx_sel)) || (m_row >= POS_W'(by_sel));
                s1_last_reg <= mcu_end;
            end
        end
    end

    // second stage: block index, then hold for the result transaction
    logic [MUL_W-1:0]    idx_prod;
    logic [LIN_BITS-1:0] idx_val;

    assign idx_prod = MUL_W'(s1_row_reg) * MUL_W'(s1_bx_reg);
    assign idx_val  = s1_lin_mode_reg ? s1_lin_reg
                                      : LIN_BITS'(idx_prod + MUL_W'(s1_col_reg));

    logic [SLOT_OUT_W-1:0]  out_slot_reg;
    logic [COL_OUT_W-1:0]   out_col_reg;
    logic [ROW_OUT_W-1:0]   out_row_reg;
    logic [LIN_BITS-1:0]    out_idx_reg;
    logic signed [DC_W-1:0] out_dc_reg;
    logic                   out_past_reg, out_last_reg;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && out_free)
        begin
            out_slot_reg <= s1_slot_reg;
            out_col_reg  <= COL_OUT_W'(s1_col_reg);
            out_row_reg  <= ROW_OUT_W'(s1_row_reg);
            out_idx_reg  <= idx_val;
            out_dc_reg   <= s1_dc_reg;
            out_past_reg <= s1_past_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.slot        = out_slot_reg;
    assign result.block_col   = out_col_reg;
    assign result.block_row   = out_row_reg;
    assign result.block_index = out_idx_reg;
    assign result.dc_value    = out_dc_reg;
    assign result.past_end    = out_past_reg;
    assign result.mcu_last    = out_last_reg;

endmodule

>>> verif/tb.sv
// Self-checking testbench for the JPEG MCU block sequencer with DC prediction.
// Drives directed and random request transactions, predicts each block result
// and compares it with the result channel. Depends on jmdp_pkg, jmdp_if and the sequencer top.
`timescale 1ns / 1ps

module tb;
    import jmdp_pkg::*;

    localparam logic [REQ_TYPE_W-1:0] REQ_IGNORED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0]  REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0]  REG_SPARE_HI = 3'd7;
    localparam int SLOT_COUNT   = DEF_MAX_SLOTS;
    localparam int COORD_MAX    = (1 << DEF_COORD_BITS) - 1;
    localparam int REPORT_LIMIT = 10;
    localparam int TARGET_ITEMS = 800;
    localparam int DIR_ROWS     = 27;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot;
        logic [COL_OUT_W-1:0]  col;
        logic [ROW_OUT_W-1:0]  row;
        logic [LIN_BITS-1:0]   index;
        logic [DC_W-1:0]       dc;
        logic                  past;
        logic                  last;
    } block_result_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_CHECK} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [2:0]         code;
        logic [31:0]        value;
        block_result_t      want;
    } dir_row_t;

    typedef enum logic [1:0] {SINK_FREE, SINK_RANDOM, SINK_PULSE, SINK_HOLD} sink_mode_t;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{ROW_CHECK, REQ_BLOCK,   32'h7FFF, '{2'd0, 13'd0, 13'd0, 26'd0, 16'h7FFF, 1'b0, 1'b1}},
        '{ROW_CHECK, REQ_BLOCK,   32'h0001, '{2'd0, 13'd0, 13'd1, 26'd1, 16'h8000, 1'b1, 1'b1}},
        '{ROW_CHECK, REQ_BLOCK,   32'h8000, '{2'd0, 13'd0, 13'd2, 26'd2, 16'h0000, 1'b1, 1'b1}},
        '{ROW_ITEM,  REQ_RESTART, 32'h0000, '0},
        '{ROW_CHECK, REQ_BLOCK,   32'hFFFF, '{2'd0, 13'd0, 13'd3, 26'd3, 16'hFFFF, 1'b1, 1'b1}},
        '{ROW_ITEM,  REQ_IGNORED, 32'hA5A5, '0},
        '{ROW_ITEM,  REQ_START,   32'h0000, '0},
        '{ROW_CHECK, REQ_BLOCK,   32'h0000, '{2'd0, 13'd0, 13'd0, 26'd0, 16'h0000, 1'b0, 1'b1}},
        '{ROW_CFG,   REG_SCAN_COMPONENTS,       32'd3,          '0},
        '{ROW_CFG,   REG_MCU_COLUMNS,           32'd2,          '0},
        '{ROW_CFG,   REG_SLOT0_GEOMETRY,        32'h0010_0112,  '0},
        '{ROW_CFG,   REG_SLOT0_GEOMETRY + 3'd1, 32'h0008_0089,  '0},
        '{ROW_CFG,   REG_SLOT0_GEOMETRY + 3'd2, 32'h0008_0089,  '0},
        '{ROW_ITEM,  REQ_START,   32'h0000, '0},
        '{ROW_ITEM,  REQ_BLOCK,   32'h7FFF, '0},
        '{ROW_ITEM,  REQ_BLOCK,   32'h0001, '0},
        '{ROW_ITEM,  REQ_BLOCK,   32'h8000, '0},
        '{ROW_ITEM,  REQ_BLOCK,   32'hFFFF, '0},
        '{ROW_ITEM,  REQ_BLOCK,   32'h0100, '0},
        '{ROW_ITEM,  REQ_BLOCK,   32'h0002, '0},
        '{ROW_ITEM,  REQ_BLOCK,   32'h8001, '0},
        '{ROW_ITEM,  REQ_BLOCK,   32'h0003, '0},
        '{ROW_ITEM,  REQ_RESTART, 32'h0000, '0},
        '{ROW_ITEM,  REQ_BLOCK,   32'h0005, '0},
        '{ROW_ITEM,  REQ_BLOCK,   32'h7FFE, '0},
        '{ROW_CFG,   REG_SCAN_COMPONENTS,       32'd0,          '0},
        '{ROW_ITEM,  REQ_BLOCK,   32'h4321, '0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    jmdp_item_if   item_ch ();
    jmdp_result_if result_ch ();

    jpeg_mcu_block_sequencer_dc_predict_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    always #4 clk = ~clk;

    // predictor copy of configuration and sequencer state
    logic [SCAN_W-1:0]     cfg_scan;
    logic [MCU_COLS_W-1:0] cfg_mcu_cols;
    logic [GEOM_W-1:0]     cfg_geom [SLOT_COUNT];
    logic [DC_W-1:0]       dc_pred [SLOT_COUNT];
    logic [12:0]           mcu_x;
    logic [12:0]           mcu_y;
    logic [1:0]            comp_pos;
    logic [SUB_W-1:0]      blk_h;
    logic [SUB_W-1:0]      blk_v;
    logic [LIN_BITS-1:0]   raster_pos;

    block_result_t due_blocks [$];
    block_result_t seen_blk;
    block_result_t due_blk;
    int fail_count = 0;
    int work_items = 0;
    int burst_left = 0;

    logic [7:0] sink_tick = '0;
    sink_mode_t sink_mode = SINK_FREE;

    task automatic clear_dc_pred();
        for (int k = 0; k < SLOT_COUNT; k++)
            dc_pred[k] = '0;
    endtask

    task automatic advance_sequencer(input logic [1:0] r, input logic [DC_W-1:0] d,
                                     output bit produced, output block_result_t res);
        logic [GEOM_W-1:0] g;
        int unsigned ns;
        int unsigned h;
        int unsigned v;
        int unsigned bx;
        int unsigned by;
        int unsigned nc;
        logic [63:0] col;
        logic [63:0] row;
        logic [63:0] idx;
        logic [1:0] s;
        logic [DC_W-1:0] sum;
        bit past;
        bit last;
        produced = 1'b0;
        res = '0;
        if (r == REQ_START) begin
            clear_dc_pred();
            mcu_x = '0;
            mcu_y = '0;
            comp_pos = '0;
            blk_h = '0;
            blk_v = '0;
            raster_pos = '0;
        end
        else if (r == REQ_RESTART) begin
            clear_dc_pred();
        end
        else if (r == REQ_BLOCK && cfg_scan != '0) begin
            produced = 1'b1;
            ns = (cfg_scan > SLOT_COUNT) ? SLOT_COUNT : cfg_scan;
            if (ns == 1) begin
                s = '0;
                g = cfg_geom[0];
                bx = g[18:6];
                by = g[31:19];
                if (bx == 0) begin
                    col = '0;
                    row = raster_pos;
                    past = 1'b1;
                end
                else begin
                    col = 64'(raster_pos) % 64'(bx);
                    row = 64'(raster_pos) / 64'(bx);
                    past = 64'(raster_pos) >= 64'(bx) * 64'(by);
                end
                idx = raster_pos;
                last = 1'b1;
                raster_pos = raster_pos + 1'b1;
            end
            else begin
                s = comp_pos;
                g = cfg_geom[s];
                h = g[2:0];
                v = g[5:3];
                bx = g[18:6];
                by = g[31:19];
                if (h == 0)
                    h = 1;
                if (v == 0)
                    v = 1;
                col = 64'(mcu_x) * 64'(h) + 64'(blk_h);
                row = 64'(mcu_y) * 64'(v) + 64'(blk_v);
                past = (col >= 64'(bx)) || (row >= 64'(by));
                idx = row * 64'(bx) + col;
                last = 1'b0;
                blk_h = blk_h + 1'b1;
                if (blk_h >= h) begin
                    blk_h = '0;
                    blk_v = blk_v + 1'b1;
                    if (blk_v >= v) begin
                        blk_v = '0;
                        if (32'(comp_pos) + 1 >= ns) begin
                            nc = 32'(mcu_x) + 1;
                            comp_pos = '0;
                            last = 1'b1;
                            if (nc >= cfg_mcu_cols || nc > COORD_MAX) begin
                                mcu_x = '0;
                                mcu_y = mcu_y + 1'b1;
                            end
                            else begin
                                mcu_x = nc[12:0];
                            end
                        end
                        else begin
                            comp_pos = comp_pos + 1'b1;
                        end
                    end
                end
            end
            sum = d + dc_pred[s];
            dc_pred[s] = sum;
            res.slot = s;
            res.col = col[COL_OUT_W-1:0];
            res.row = row[ROW_OUT_W-1:0];
            res.index = idx[LIN_BITS-1:0];
            res.dc = sum;
            res.past = past;
            res.last = last;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_SCAN_COMPONENTS)
            cfg_scan = data[SCAN_W-1:0];
        else if (idx == REG_MCU_COLUMNS)
            cfg_mcu_cols = data[MCU_COLS_W-1:0];
        else if (idx >= REG_SLOT0_GEOMETRY && idx <= REG_SLOT0_GEOMETRY + 3'd3)
            cfg_geom[idx - REG_SLOT0_GEOMETRY] = data;
    endtask

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (due_blocks.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_item(input logic [1:0] r, input logic [DC_W-1:0] d,
                             input bit typed, input block_result_t want);
        int gap;
        bit produced;
        block_result_t res;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        item_ch.valid <= 1'b1;
        item_ch.req_type <= r;
        item_ch.dc_diff <= d;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        advance_sequencer(r, d, produced, res);
        if (produced)
            due_blocks.push_back(typed ? want : res);
        if (produced || r == REQ_START || r == REQ_RESTART)
            work_items++;
    endtask

    function automatic logic [12:0] rand_extent();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 13'(COORD_MAX);
            2: return 13'($urandom);
            default: return 13'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [31:0] rand_geom();
        logic [2:0] h;
        logic [2:0] v;
        logic [12:0] bx;
        logic [12:0] by;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        h = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 2));
        v = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 2));
        bx = rand_extent();
        by = rand_extent();
        return {by, bx, v, h};
    endfunction

    function automatic logic [DC_W-1:0] rand_diff();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 7)) - 16'd3;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_phase(input int phase);
        int n;
        int pick;
        logic [31:0] noise;
        logic [31:0] scan_val;
        logic [31:0] cols_val;
        wait_idle();
        noise = ($urandom_range(0, 3) == 0) ? $urandom : 32'h0;
        if (phase == 0) begin
            write_reg(REG_SCAN_COMPONENTS, 32'd4);
            write_reg(REG_MCU_COLUMNS, 32'd8192);
            for (int k = 0; k < SLOT_COUNT; k++)
                write_reg(REG_SLOT0_GEOMETRY + 3'(k), 32'hFFFF_FFFF);
            write_reg(REG_SPARE_LO, $urandom);
            write_reg(REG_SPARE_HI, $urandom);
        end
        else if (phase == 1) begin
            write_reg(REG_SCAN_COMPONENTS, (noise & ~32'h7) | 32'd7);
            write_reg(REG_MCU_COLUMNS, 32'd0);
            for (int k = 0; k < SLOT_COUNT; k++)
                write_reg(REG_SLOT0_GEOMETRY + 3'(k), 32'h0);
        end
        else if (phase == 2) begin
            write_reg(REG_SCAN_COMPONENTS, 32'd1);
            write_reg(REG_SLOT0_GEOMETRY, {rand_extent(), 13'd0, 6'($urandom)});
        end
        else begin
            pick = $urandom_range(0, 9);
            scan_val = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(5, 7) : $urandom_range(1, 4);
            case ($urandom_range(0, 6))
                4: cols_val = 32'd8192;
                5: cols_val = 32'h3FFF;
                6: cols_val = 32'($urandom_range(0, 16383));
                default: cols_val = $urandom_range(0, 4);
            endcase
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_SCAN_COMPONENTS, (noise & ~32'h7) | scan_val);
            if ($urandom_range(0, 1) != 0)
                write_reg(REG_MCU_COLUMNS, (noise & ~32'h3FFF) | cols_val);
            for (int k = 0; k < SLOT_COUNT; k++)
                if ($urandom_range(0, 1) != 0)
                    write_reg(REG_SLOT0_GEOMETRY + 3'(k), rand_geom());
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
        end
        if (phase < 3 || $urandom_range(0, 9) != 0)
            send_item(REQ_START, 16'($urandom), 1'b0, '0);
        n = $urandom_range(30, 80);
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 86)
                send_item(REQ_BLOCK, rand_diff(), 1'b0, '0);
            else if (pick < 92)
                send_item(REQ_RESTART, 16'($urandom), 1'b0, '0);
            else if (pick < 96)
                send_item(REQ_START, 16'($urandom), 1'b0, '0);
            else
                send_item(REQ_IGNORED, 16'($urandom), 1'b0, '0);
        end
    endtask

    always @(posedge clk) begin
        sink_tick <= sink_tick + 1'b1;
        if (sink_tick == '0)
            sink_mode <= sink_mode_t'($urandom_range(0, 3));
        case (sink_mode)
            SINK_FREE:   result_ch.ready <= 1'b1;
            SINK_RANDOM: result_ch.ready <= ($urandom_range(0, 2) != 0);
            SINK_PULSE:  result_ch.ready <= (sink_tick[1:0] == 2'b11);
            default:     result_ch.ready <= sink_tick[4];
        endcase
    end

    always @(posedge clk) begin
        if (rst_n && result_ch.valid && result_ch.ready) begin
            seen_blk.slot = result_ch.slot;
            seen_blk.col = result_ch.block_col;
            seen_blk.row = result_ch.block_row;
            seen_blk.index = result_ch.block_index;
            seen_blk.dc = result_ch.dc_value;
            seen_blk.past = result_ch.past_end;
            seen_blk.last = result_ch.mcu_last;
            if (due_blocks.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result transaction at %0t: slot %0d idx %0d",
                             $realtime, seen_blk.slot, seen_blk.index);
            end
            else begin
                due_blk = due_blocks.pop_front();
                if (seen_blk !== due_blk) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("mismatch at %0t", $realtime);
                        $display("  want slot %0d col %0d row %0d idx %0d dc %0d past %0b last %0b",
                                 due_blk.slot, due_blk.col, due_blk.row, due_blk.index,
                                 $signed(due_blk.dc), due_blk.past, due_blk.last);
                        $display("  got  slot %0d col %0d row %0d idx %0d dc %0d past %0b last %0b",
                                 seen_blk.slot, seen_blk.col, seen_blk.row, seen_blk.index,
                                 $signed(seen_blk.dc), seen_blk.past, seen_blk.last);
                    end
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        int phase;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.req_type = '0;
        item_ch.dc_diff = '0;
        result_ch.ready = 1'b0;
        cfg_scan = SCAN_COMPONENTS_RESET;
        cfg_mcu_cols = MCU_COLUMNS_RESET;
        for (int k = 0; k < SLOT_COUNT; k++)
            cfg_geom[k] = GEOM_RESET;
        clear_dc_pred();
        mcu_x = '0;
        mcu_y = '0;
        comp_pos = '0;
        blk_h = '0;
        blk_v = '0;
        raster_pos = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIR_TABLE[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(DIR_TABLE[i].code, DIR_TABLE[i].value);
            end
            else begin
                send_item(DIR_TABLE[i].code[1:0], DIR_TABLE[i].value[DC_W-1:0],
                          DIR_TABLE[i].kind == ROW_CHECK, DIR_TABLE[i].want);
            end
        end

        work_items = 0;
        phase = 0;
        while (work_items < TARGET_ITEMS) begin
            run_phase(phase);
            phase++;
        end

        wait_idle();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
